// File: rtl/hds_pkg.sv
// Shared types and constants for the 2D heat diffusion stencil core.
`default_nettype none
package hds_pkg;
    localparam int MAX_COLS  = 128;
    localparam int MAX_ROWS  = 4096;
    localparam int FRAC_BITS = 12;
    localparam int TEMP_W    = 24;
    localparam int FACTOR_W  = 15;
    localparam int COLS_W    = 8;
    localparam int ROWS_W    = 13;
    localparam logic [FACTOR_W-1:0] FACTOR_QUARTER = 15'd16384;
    localparam logic [1:0] CFG_FACTOR   = 2'd0;
    localparam logic [1:0] CFG_COLUMNS  = 2'd1;
    localparam logic [1:0] CFG_ROWS     = 2'd2;
    localparam logic [1:0] CFG_BOUNDARY = 2'd3;
    localparam int CFG_ADDR_W = 2;

    typedef struct packed {
        logic              boundary;
        logic signed [TEMP_W-1:0] u;
        logic signed [TEMP_W-1:0] n;
        logic signed [TEMP_W-1:0] s;
        logic signed [TEMP_W-1:0] w;
        logic signed [TEMP_W-1:0] e;
        logic [11:0]       row;
        logic [6:0]        col;
        logic              last;
        logic              second;
        logic [11:0]       row2;
        logic              last2;
    } t_job;
endpackage
`default_nettype wire

// File: rtl/hds_front.sv
// Front end: position tracking, line buffers, window and job classification.
`default_nettype none
module hds_front #(
    parameter int MAX_COLS = hds_pkg::MAX_COLS,
    parameter int MAX_ROWS = hds_pkg::MAX_ROWS
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_valid,
    input  wire                            i_take,
    input  wire signed [hds_pkg::TEMP_W-1:0] i_cell,
    input  wire                            i_frame_start,
    input  wire [hds_pkg::COLS_W-1:0]      i_cols,
    input  wire [hds_pkg::ROWS_W-1:0]      i_rows,
    output logic                           o_valid,
    output hds_pkg::t_job                  o_job
);
    localparam int CW = $clog2(MAX_COLS);
    localparam int RW = $clog2(MAX_ROWS);
    localparam int CC = (CW > hds_pkg::COLS_W ? CW : hds_pkg::COLS_W) + 1;
    localparam int RC = (RW > hds_pkg::ROWS_W ? RW : hds_pkg::ROWS_W) + 1;

    logic signed [hds_pkg::TEMP_W-1:0] r_older [MAX_COLS];
    logic signed [hds_pkg::TEMP_W-1:0] r_newer [MAX_COLS];
    logic signed [hds_pkg::TEMP_W-1:0] r_w1;
    logic [RC-1:0] r_row;
    logic [CC-1:0] r_col;

    // stage A registers (memory read issued)
    logic                 r_av;
    logic [CW-1:0]        r_ac;
    logic [RC-1:0]        r_ar;
    logic                 r_a_has_right;
    logic                 r_a_rowok, r_a_lastrow, r_a_bnd, r_a_lastc;
    logic signed [hds_pkg::TEMP_W-1:0] r_acell;
    logic signed [hds_pkg::TEMP_W-1:0] r_rd_c, r_rd_r, r_rd_o;
    logic                 r_fwd_c, r_fwd_r;

    logic [CC-1:0] nc;
    logic [RC-1:0] nr;
    logic [CC-1:0] n_c;
    logic [RC-1:0] n_r;
    logic [CC-1:0] c1;
    logic [RC-1:0] n_rowp;
    logic [CC-1:0] n_colp;
    logic          acc;

    always_comb begin
        if (CC'(i_cols) < CC'(3)) nc = CC'(3);
        else if (CC'(i_cols) > CC'(MAX_COLS)) nc = CC'(MAX_COLS);
        else nc = CC'(i_cols);
        if (RC'(i_rows) < RC'(3)) nr = RC'(3);
        else if (RC'(i_rows) > RC'(MAX_ROWS)) nr = RC'(MAX_ROWS);
        else nr = RC'(i_rows);
        n_r = i_frame_start ? '0 : r_row;
        n_c = i_frame_start ? '0 : r_col;
        if (n_c >= nc) begin
            n_c = '0;
            n_r = n_r + RC'(1);
        end
        if (n_r >= nr) n_r = '0;
        c1 = n_c + CC'(1);
        n_rowp = n_r;
        n_colp = c1;
        if (c1 >= nc) begin
            n_colp = '0;
            n_rowp = n_r + RC'(1);
            if (n_rowp >= nr) n_rowp = '0;
        end
    end

    assign acc = i_valid && i_take;

    // Line buffer writes happen in stage A; same-column reads of the
    // next item bypass the pending writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
            r_av  <= 1'b0;
            r_w1  <= '0;
        end else begin
            if (acc) begin
                r_row <= n_rowp;
                r_col <= n_colp;
            end
            if (i_take) r_av <= acc;
            if (r_av && i_take) begin
                r_w1 <= r_fwd_c ? r_acell : r_rd_c;
            end
        end
    end

    logic signed [hds_pkg::TEMP_W-1:0] cur_c, cur_r;
    assign cur_c = r_fwd_c ? r_acell : r_rd_c;
    assign cur_r = r_fwd_r ? r_acell : r_rd_r;

    always_ff @(posedge i_clk) begin
        if (r_av && i_take) begin
            r_older[r_ac] <= cur_c;
            r_newer[r_ac] <= r_acell;
        end
        if (acc) begin
            r_ac          <= CW'(n_c);
            r_ar          <= n_r;
            r_acell       <= i_cell;
            r_a_has_right <= c1 < nc;
            r_a_rowok     <= n_r != '0;
            r_a_lastrow   <= n_r == nr - RC'(1);
            r_a_lastc     <= n_c == nc - CC'(1);
            r_a_bnd       <= (n_r == RC'(1)) || (n_c == '0) || (n_c == nc - CC'(1));
            r_rd_c        <= r_newer[CW'(n_c)];
            r_rd_r        <= r_newer[CW'(c1)];
            r_rd_o        <= r_older[CW'(n_c)];
            r_fwd_c       <= r_av && (r_ac == CW'(n_c));
            r_fwd_r       <= r_av && (r_ac == CW'(c1));
        end
    end

    // r_rd_o for same column only clashes on a restart at row 0, where it is unused.
    always_comb begin
        o_valid         = r_av && r_a_rowok;
        o_job.boundary  = r_a_bnd;
        o_job.u         = cur_c;
        o_job.n         = r_rd_o;
        o_job.s         = r_acell;
        o_job.w         = r_w1;
        o_job.e         = r_a_has_right ? cur_r : '0;
        o_job.row       = 12'(r_ar - RC'(1));
        o_job.col       = 7'(r_ac);
        o_job.last      = 1'b0;
        o_job.second    = r_a_lastrow;
        o_job.row2      = 12'(r_ar);
        o_job.last2     = r_a_lastc;
    end
endmodule
`default_nettype wire

// File: rtl/hds_fifo.sv
// Short queue between front end and back end.
`default_nettype none
module hds_fifo #(
    parameter int DEPTH = 4
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_push,
    input  hds_pkg::t_job  i_data,
    output logic           o_full,
    output logic           o_empty,
    input  wire            i_pop,
    output hds_pkg::t_job  o_data
);
    localparam int AW = $clog2(DEPTH);
    hds_pkg::t_job r_mem [DEPTH];
    logic [AW:0] r_wp, r_rp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + (AW+1)'(1);
            if (i_pop)  r_rp <= r_rp + (AW+1)'(1);
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp[AW-1:0]] <= i_data;
    end
    assign o_data  = r_mem[r_rp[AW-1:0]];
    assign o_empty = r_wp == r_rp;
    assign o_full  = (r_wp[AW] != r_rp[AW]) && (r_wp[AW-1:0] == r_rp[AW-1:0]);
endmodule
`default_nettype wire

// File: rtl/hds_back.sv
// Back end: stencil arithmetic, rounding, saturation and result sequencing.
`default_nettype none
module hds_back (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_empty,
    input  hds_pkg::t_job                  i_job,
    output logic                           o_pop,
    input  wire [hds_pkg::FACTOR_W-1:0]    i_factor,
    input  wire signed [hds_pkg::TEMP_W-1:0] i_bound,
    output logic                           o_valid,
    input  wire                            i_stall,
    output logic signed [hds_pkg::TEMP_W-1:0] o_temp,
    output logic [11:0]                    o_row,
    output logic [6:0]                     o_col,
    output logic                           o_last
);
    localparam int TW = hds_pkg::TEMP_W;
    // stage 1: sum; stage 2: product; stage 3: round/sat -> output
    logic r_v1, r_v2, r_v3, r_half;
    logic signed [TW+3:0] r_sum;
    logic signed [TW-1:0] r_u1, r_u2;
    logic signed [TW+20:0] r_prod;
    hds_pkg::t_job r_j1, r_j2;
    hds_pkg::t_job j_in;
    logic [hds_pkg::FACTOR_W-1:0] f;
    logic adv;
    logic signed [TW+20:0] rnd;
    logic signed [TW+5:0] d, rr;
    logic signed [TW-1:0] sat;

    assign adv = !r_v3 || !i_stall;
    // second result of a last-row job keeps the job at the queue head until that result issues
    assign o_pop = adv && !i_empty && (!i_job.second || r_half) && 1'b1;
    assign f = (i_factor > hds_pkg::FACTOR_QUARTER) ? hds_pkg::FACTOR_QUARTER : i_factor;

    always_comb begin
        j_in          = i_job;
        j_in.boundary = i_job.boundary || r_half;
        j_in.row      = r_half ? i_job.row2 : i_job.row;
        j_in.last     = r_half && i_job.last2;
    end

    always_comb begin
        rnd = r_prod + (TW+21)'(32768);
        d   = (TW+6)'(rnd >>> 16);
        rr  = d + (TW+6)'(r_u2);
        if (rr > (TW+6)'(8388607)) sat = 24'sh7FFFFF;
        else if (rr < -(TW+6)'(8388608)) sat = 24'sh800000;
        else sat = TW'(rr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0; r_half <= 1'b0;
        end else if (adv) begin
            r_v1 <= !i_empty;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (!i_empty && i_job.second) r_half <= !r_half;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_j1 <= j_in;
            r_u1 <= i_job.u;
            r_sum <= (TW+4)'(i_job.n) + (TW+4)'(i_job.s) + (TW+4)'(i_job.w)
                   + (TW+4)'(i_job.e) - ((TW+4)'(i_job.u) <<< 2);
            r_j2 <= r_j1;
            r_u2 <= r_u1;
            r_prod <= (TW+21)'(r_sum) * $signed({1'b0, f});
            o_temp <= r_j2.boundary ? i_bound : sat;
            o_row  <= r_j2.row;
            o_col  <= r_j2.col;
            o_last <= r_j2.last;
        end
    end
    assign o_valid = r_v3;
endmodule
`default_nettype wire

// File: rtl/heat_diffusion_stencil_2d_core.sv
// A result passes front stage A, the short queue and the sum, product and round/sat registers.
// Throughput: one item per cycle while o_stall is low; on the last row two results per item,
// so input stalls through the short queue while the back end emits both.
// Line buffers are flop arrays read at the front end: two read ports on the newer row, one on the older.
// Reset: synchronous, active low; clears position, window and pipeline valids; loads config defaults.
`default_nettype none
module heat_diffusion_stencil_2d_core #(
    parameter int MAX_COLS = hds_pkg::MAX_COLS,
    parameter int MAX_ROWS = hds_pkg::MAX_ROWS
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_valid,
    output logic                            o_stall,
    input  wire signed [hds_pkg::TEMP_W-1:0] i_cell_temp,
    input  wire                             i_frame_start,
    output logic                            o_valid,
    input  wire                             i_stall,
    output logic signed [hds_pkg::TEMP_W-1:0] o_new_temp,
    output logic [11:0]                     o_out_row,
    output logic [6:0]                      o_out_col,
    output logic                            o_frame_last,
    input  wire                             i_cfg_we,
    input  wire [hds_pkg::CFG_ADDR_W-1:0]   i_cfg_index,
    input  wire [hds_pkg::TEMP_W-1:0]       i_cfg_data
);
    logic [hds_pkg::FACTOR_W-1:0] r_factor;
    logic [hds_pkg::COLS_W-1:0]   r_cols;
    logic [hds_pkg::ROWS_W-1:0]   r_rows;
    logic signed [hds_pkg::TEMP_W-1:0] r_bound;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor <= hds_pkg::FACTOR_QUARTER;
            r_cols   <= 8'd100;
            r_rows   <= 13'd100;
            r_bound  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                hds_pkg::CFG_FACTOR:   r_factor <= i_cfg_data[hds_pkg::FACTOR_W-1:0];
                hds_pkg::CFG_COLUMNS:  r_cols   <= i_cfg_data[hds_pkg::COLS_W-1:0];
                hds_pkg::CFG_ROWS:     r_rows   <= i_cfg_data[hds_pkg::ROWS_W-1:0];
                hds_pkg::CFG_BOUNDARY: r_bound  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic fv, full, empty, pop, take;
    hds_pkg::t_job fjob, qjob;
    // front advances only when the queue has room for its pending job
    assign take = !full;
    assign o_stall = full;

    hds_front #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_take(take),
        .i_cell(i_cell_temp), .i_frame_start(i_frame_start),
        .i_cols(r_cols), .i_rows(r_rows), .o_valid(fv), .o_job(fjob));

    hds_fifo #(.DEPTH(4)) u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(fv && take), .i_data(fjob),
        .o_full(full), .o_empty(empty), .i_pop(pop), .o_data(qjob));

    hds_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_empty(empty), .i_job(qjob),
        .o_pop(pop), .i_factor(r_factor), .i_bound(r_bound),
        .o_valid(o_valid), .i_stall(i_stall), .o_temp(o_new_temp),
        .o_row(o_out_row), .o_col(o_out_col), .o_last(o_frame_last));

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !(fv && take)) else $error("queue overflow");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !empty) else $error("pop from empty queue");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid) else $error("result dropped");
endmodule
`default_nettype wire

// File: tb/heat_diffusion_stencil_2d_core_tb.sv
// Testbench for the 2D heat diffusion stencil core: random and directed frames, scoreboard.
`timescale 1ns / 100ps
module heat_diffusion_stencil_2d_core_tb;

    typedef struct {
        logic signed [hds_pkg::TEMP_W-1:0] temp;
        logic                              start;
    } t_cell_item;

    typedef struct {
        logic signed [hds_pkg::TEMP_W-1:0] temp;
        logic [11:0]                       row;
        logic [6:0]                        col;
        logic                              last;
    } t_cell_result;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TEMP_HI = 8388607;
    localparam int TEMP_LO = -8388608;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_valid;
    logic                              o_stall;
    logic signed [hds_pkg::TEMP_W-1:0] i_cell_temp;
    logic                              i_frame_start;
    logic                              o_valid;
    logic                              i_stall;
    logic signed [hds_pkg::TEMP_W-1:0] o_new_temp;
    logic [11:0]                       o_out_row;
    logic [6:0]                        o_out_col;
    logic                              o_frame_last;
    logic                              i_cfg_we;
    logic [hds_pkg::CFG_ADDR_W-1:0]    i_cfg_index;
    logic [hds_pkg::TEMP_W-1:0]        i_cfg_data;

    heat_diffusion_stencil_2d_core u_top (.*);

    t_cell_item   pending_cells[$];
    t_cell_result expected_cells[$];
    t_idle_mode   idle_mode;
    int           fail_count;
    int           quiet_cycles;
    bit           in_fire;

    // predictor state
    int  older_row[hds_pkg::MAX_COLS];
    int  newer_row[hds_pkg::MAX_COLS];
    int  win_left, win_mid, win_right;
    int  pos_row, pos_col;
    int  factor_reg, cols_reg, rows_reg, boundary_reg;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int heat_update(int u, int n, int s, int w, int e);
        longint sum;
        longint f;
        longint res;
        sum = longint'(n) + s + w + e - 4 * longint'(u);
        f = (factor_reg > hds_pkg::FACTOR_QUARTER) ? hds_pkg::FACTOR_QUARTER : factor_reg;
        res = u + ((sum * f + 32768) >>> 16);
        if (res > TEMP_HI) res = TEMP_HI;
        if (res < TEMP_LO) res = TEMP_LO;
        return int'(res);
    endfunction

    function automatic void push_result(int t, int r, int c, bit last);
        t_cell_result x;
        x.temp = t[hds_pkg::TEMP_W-1:0];
        x.row = r[11:0];
        x.col = c[6:0];
        x.last = last;
        expected_cells.push_back(x);
    endfunction

    function automatic void predict_cell(logic signed [hds_pkg::TEMP_W-1:0] temp, logic start);
        int nc, nr, r, c, t, cell_val;
        nc = (cols_reg < 3) ? 3 : (cols_reg > hds_pkg::MAX_COLS) ? hds_pkg::MAX_COLS : cols_reg;
        nr = (rows_reg < 3) ? 3 : (rows_reg > hds_pkg::MAX_ROWS) ? hds_pkg::MAX_ROWS : rows_reg;
        cell_val = temp;
        if (start) begin
            pos_row = 0;
            pos_col = 0;
        end
        r = pos_row;
        c = pos_col;
        if (c >= nc) begin
            c = 0;
            r++;
        end
        if (r >= nr) r = 0;
        win_left = win_mid;
        win_mid = newer_row[c];
        win_right = (c + 1 < nc) ? newer_row[c + 1] : 0;
        if (r >= 1) begin
            if (r == 1 || c == 0 || c == nc - 1)
                t = boundary_reg;
            else
                t = heat_update(win_mid, older_row[c], cell_val, win_left, win_right);
            push_result(t, r - 1, c, 1'b0);
            if (r == nr - 1) push_result(boundary_reg, r, c, c == nc - 1);
        end
        older_row[c] = win_mid;
        newer_row[c] = cell_val;
        c++;
        if (c >= nc) begin
            c = 0;
            r++;
            if (r >= nr) r = 0;
        end
        pos_row = r;
        pos_col = c;
    endfunction

    task automatic write_reg(logic [hds_pkg::CFG_ADDR_W-1:0] idx, int value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value[hds_pkg::TEMP_W-1:0];
        case (idx)
            hds_pkg::CFG_FACTOR:   factor_reg = value & 32'h7FFF;
            hds_pkg::CFG_COLUMNS:  cols_reg = value & 32'hFF;
            hds_pkg::CFG_ROWS:     rows_reg = value & 32'h1FFF;
            hds_pkg::CFG_BOUNDARY: boundary_reg = int'(signed'(value[hds_pkg::TEMP_W-1:0]));
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic setup(int factor, int ncols, int nrows, int boundary);
        write_reg(hds_pkg::CFG_FACTOR, factor);
        write_reg(hds_pkg::CFG_COLUMNS, ncols);
        write_reg(hds_pkg::CFG_ROWS, nrows);
        write_reg(hds_pkg::CFG_BOUNDARY, boundary);
    endtask

    function automatic logic signed [hds_pkg::TEMP_W-1:0] rand_temp(int base);
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) return TEMP_HI;
        if (k == 1) return TEMP_LO;
        if (k < 5) return $urandom();
        return base + int'($urandom_range(0, 8191)) - 4096;
    endfunction

    task automatic load_cells(int count, bit with_start, int noise_pct);
        t_cell_item x;
        int base;
        base = int'($urandom_range(0, 4194303)) - 2097152;
        for (int k = 0; k < count; k++) begin
            x.temp = rand_temp(base);
            x.start = (with_start && k == 0) || ($urandom_range(0, 99) < noise_pct);
            pending_cells.push_back(x);
        end
    endtask

    task automatic run_phase(t_idle_mode mode);
        idle_mode = mode;
        wait (pending_cells.size() == 0 && !i_valid && expected_cells.size() == 0);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic directed_frame(int mid, int edge_val);
        t_cell_item x;
        for (int k = 0; k < 9; k++) begin
            x.temp = (k == 4) ? mid : edge_val;
            x.start = (k == 0);
            pending_cells.push_back(x);
        end
    endtask

    // input side
    always @(posedge i_clk) begin
        in_fire <= i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall) predict_cell(i_cell_temp, i_frame_start);
    end

    always @(negedge i_clk) begin
        bit gap, stall_now;
        t_cell_item x;
        gap = (idle_mode == IDLE_SEND && $urandom_range(0, 99) < 58) ||
              (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 21);
        stall_now = (idle_mode == IDLE_RECV && $urandom_range(0, 99) < 58) ||
                    (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 21);
        i_stall <= stall_now;
        if (i_rst_n && (!i_valid || in_fire)) begin
            if (!gap && pending_cells.size() > 0) begin
                x = pending_cells.pop_front();
                i_valid <= 1'b1;
                i_cell_temp <= x.temp;
                i_frame_start <= x.start;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // output side and watchdog
    always @(posedge i_clk) begin
        t_cell_result x;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_cells.size() == 0) begin
                $display("%0t: unexpected result temp=%0d row=%0d col=%0d last=%0b",
                         $time, o_new_temp, o_out_row, o_out_col, o_frame_last);
                fail_count++;
            end else begin
                x = expected_cells.pop_front();
                if (o_new_temp !== x.temp || o_out_row !== x.row ||
                    o_out_col !== x.col || o_frame_last !== x.last) begin
                    $display("%0t: mismatch expected temp=%0d row=%0d col=%0d last=%0b",
                             $time, x.temp, x.row, x.col, x.last);
                    $display("%0t:            actual temp=%0d row=%0d col=%0d last=%0b",
                             $time, o_new_temp, o_out_row, o_out_col, o_frame_last);
                    fail_count++;
                end
            end
        end
        if ((i_valid && !o_stall) || (o_valid && !i_stall) ||
            (pending_cells.size() == 0 && !i_valid && expected_cells.size() == 0))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_cell_temp = '0;
        i_frame_start = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        idle_mode = IDLE_NONE;
        fail_count = 0;
        quiet_cycles = 0;
        in_fire = 1'b0;
        win_left = 0;
        win_mid = 0;
        win_right = 0;
        pos_row = 0;
        pos_col = 0;
        factor_reg = hds_pkg::FACTOR_QUARTER;
        cols_reg = 100;
        rows_reg = 100;
        boundary_reg = 0;
        foreach (older_row[k]) begin
            older_row[k] = 0;
            newer_row[k] = 0;
        end
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // smallest grid, extreme temperatures, factor above the stable limit
        setup(32767, 3, 3, TEMP_HI);
        directed_frame(TEMP_LO, TEMP_HI);
        directed_frame(TEMP_HI, TEMP_LO);
        run_phase(IDLE_NONE);

        setup($urandom_range(0, 16384), 5, 4, TEMP_LO);
        load_cells(60, 1'b1, 0);
        run_phase(IDLE_NONE);

        // widest row, zero factor
        setup(0, 128, 3, $urandom());
        load_cells(384, 1'b1, 0);
        run_phase(IDLE_SEND);

        // sizes below range clamp to 3x3, frames wrap without a start flag
        setup(16384, 2, 0, $urandom());
        load_cells(54, 1'b1, 0);
        run_phase(IDLE_RECV);

        // sizes above range clamp, restarts mid frame
        setup($urandom_range(0, 16384), 255, 8191, $urandom());
        load_cells(200, 1'b1, 2);
        run_phase(IDLE_BOTH);

        setup($urandom_range(0, 32767), 7, 6, $urandom());
        load_cells(138, 1'b1, 3);
        run_phase(IDLE_NONE);

        // shrink columns while the position is past the new row end
        setup($urandom_range(0, 16384), 4, 5, $urandom());
        load_cells(40, 1'b0, 0);
        run_phase(IDLE_SEND);

        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
